### hdl/lbms_pkg.sv
// Shared types and constants for the LED blink mode sequencer.
`timescale 1ns / 1ps

package lbms_pkg;

  localparam int LED_COUNT  = 2;
  localparam int IDX_W      = 3;
  localparam int TIME_W     = 32;
  localparam int PERIOD_W   = 16;
  localparam int COUNT_W    = 8;
  localparam int TOGGLE_W   = COUNT_W + 1;
  localparam int LEVEL_W    = 2;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 8;
  localparam int REG_IDX_W  = 1;

  localparam logic [PERIOD_W-1:0] SLOW_PERIOD_RESET = PERIOD_W'(500);
  localparam logic [PERIOD_W-1:0] FAST_PERIOD_RESET = PERIOD_W'(150);

  localparam logic [REG_IDX_W-1:0] REG_SLOW_PERIOD = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_FAST_PERIOD = REG_IDX_W'(1);

  typedef enum logic [1:0] {
    CMD_TICK      = 2'd0,
    CMD_SET_MODE  = 2'd1,
    CMD_START_SEQ = 2'd2,
    CMD_ALL_OFF   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_ON   = 2'd1,
    MODE_SLOW = 2'd2,
    MODE_FAST = 2'd3
  } mode_t;

  // Per-LED request decoded from one input item.
  typedef struct packed {
    logic                tick;
    logic                set_mode;
    logic                start_seq;
    logic                clear_all;
    logic [TIME_W-1:0]   now;
    mode_t               mode;
    logic [COUNT_W-1:0]  count;
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] slow_period;
    logic [PERIOD_W-1:0] fast_period;
  } led_ctl_t;

endpackage

### hdl/lbms_led.sv
// State and next-state logic of one LED.
`timescale 1ns / 1ps

module lbms_led (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  lbms_pkg::led_ctl_t  ctl,
  output logic                lit
);

  lbms_pkg::mode_t                      mode;
  lbms_pkg::mode_t                      mode_next;
  lbms_pkg::mode_t                      after_mode;
  lbms_pkg::mode_t                      after_mode_next;
  logic                                 lit_next;
  logic [lbms_pkg::TIME_W-1:0]          last_time;
  logic [lbms_pkg::TIME_W-1:0]          last_time_next;
  logic                                 running;
  logic                                 running_next;
  logic [lbms_pkg::TOGGLE_W-1:0]        toggles_left;
  logic [lbms_pkg::TOGGLE_W-1:0]        toggles_left_next;
  logic [lbms_pkg::PERIOD_W-1:0]        seq_period;
  logic [lbms_pkg::PERIOD_W-1:0]        seq_period_next;

  logic [lbms_pkg::TIME_W-1:0]          elapsed;
  logic [lbms_pkg::TOGGLE_W-1:0]        toggles_dec;
  logic [lbms_pkg::PERIOD_W-1:0]        blink_period;

  assign elapsed      = ctl.now - last_time;
  assign toggles_dec  = (toggles_left != '0) ? toggles_left - lbms_pkg::TOGGLE_W'(1)
                                             : toggles_left;
  assign blink_period = (mode == lbms_pkg::MODE_SLOW) ? ctl.slow_period : ctl.fast_period;

  always_comb begin
    mode_next         = mode;
    after_mode_next   = after_mode;
    lit_next          = lit;
    last_time_next    = last_time;
    running_next      = running;
    toggles_left_next = toggles_left;
    seq_period_next   = seq_period;
    if (ctl.clear_all) begin
      mode_next         = lbms_pkg::MODE_OFF;
      after_mode_next   = lbms_pkg::MODE_OFF;
      lit_next          = 1'b0;
      last_time_next    = ctl.now;
      running_next      = 1'b0;
      toggles_left_next = '0;
      seq_period_next   = '0;
    end else if (ctl.set_mode) begin
      mode_next         = ctl.mode;
      after_mode_next   = lbms_pkg::MODE_OFF;
      lit_next          = (ctl.mode != lbms_pkg::MODE_OFF);
      last_time_next    = ctl.now;
      running_next      = 1'b0;
      toggles_left_next = '0;
      seq_period_next   = '0;
    end else if (ctl.start_seq) begin
      running_next      = 1'b1;
      toggles_left_next = {ctl.count, 1'b0} - lbms_pkg::TOGGLE_W'(1);
      seq_period_next   = ctl.period;
      after_mode_next   = ctl.mode;
      last_time_next    = ctl.now;
      lit_next          = 1'b1;
    end else if (ctl.tick) begin
      if (running) begin
        if (elapsed >= lbms_pkg::TIME_W'(seq_period)) begin
          lit_next          = ~lit;
          last_time_next    = ctl.now;
          toggles_left_next = toggles_dec;
          if (toggles_dec == '0) begin
            running_next = 1'b0;
            mode_next    = after_mode;
            lit_next     = (after_mode != lbms_pkg::MODE_OFF);
          end
        end
      end else begin
        unique case (mode)
          lbms_pkg::MODE_OFF: lit_next = 1'b0;
          lbms_pkg::MODE_ON:  lit_next = 1'b1;
          default: begin
            if (elapsed >= lbms_pkg::TIME_W'(blink_period)) begin
              lit_next       = ~lit;
              last_time_next = ctl.now;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= lbms_pkg::MODE_OFF;
      after_mode   <= lbms_pkg::MODE_OFF;
      lit          <= 1'b0;
      last_time    <= '0;
      running      <= 1'b0;
      toggles_left <= '0;
      seq_period   <= '0;
    end else if (en) begin
      mode         <= mode_next;
      after_mode   <= after_mode_next;
      lit          <= lit_next;
      last_time    <= last_time_next;
      running      <= running_next;
      toggles_left <= toggles_left_next;
      seq_period   <= seq_period_next;
    end
  end

  a_running_has_toggles: assert property (@(posedge clk) disable iff (rst)
    running |-> (toggles_left != '0))
    else $error("sequence running with no toggles left");

  a_idle_no_toggles: assert property (@(posedge clk) disable iff (rst)
    !running |-> (toggles_left == '0))
    else $error("toggles left with no sequence running");

  a_clear_all_dark: assert property (@(posedge clk) disable iff (rst)
    (en && ctl.clear_all) |=> (!lit && !running && mode == lbms_pkg::MODE_OFF))
    else $error("all-off request left LED active");

endmodule

### hdl/led_blink_mode_sequencer.sv
// Top level of the LED blink mode sequencer: request register, LED array, result register.
`timescale 1ns / 1ps

// Usage:
//   s_axis carries one request per transfer: command, led_index, time_ms, mode,
//   seq_count and seq_period_ms. m_axis returns one result per request:
//   led_levels (LED 0 and 1 lit after the request) and status (1 = bad argument,
//   nothing changed). cfg writes slow_period_ms (index 0) or fast_period_ms
//   (index 1); write only while no request is in flight.
//   Path: a request accepted on s_axis is held in the request register, then the
//   per-LED update loads the LED state and the result register together.
//   Throughput: one request per cycle while m_axis does not stall; the per-LED compare and
//   toggle logic sits between the request register and the result register.
//   Reset (rst, synchronous): all LEDs off, no sequence running, timestamps zero,
//   slow period 500 ms, fast period 150 ms, both register stages empty.
//   When m_axis stalls, the result register holds; the request register still
//   takes one more request, then s_axis_tready drops until the result is taken.

module led_blink_mode_sequencer (
  input  logic                               clk,
  input  logic                               rst,
  // command[1:0], led_index[4:2], time_ms[36:5], mode[38:37],
  // seq_count[46:39], seq_period_ms[62:47], zero[63]
  input  logic [lbms_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // led_levels[1:0], status[2], zero[7:3]
  output logic [lbms_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lbms_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [lbms_pkg::PERIOD_W-1:0]      cfg_data
);

  logic [lbms_pkg::PERIOD_W-1:0] slow_period;
  logic [lbms_pkg::PERIOD_W-1:0] fast_period;

  // request register
  logic                          in_valid;
  lbms_pkg::cmd_t                in_cmd;
  logic [lbms_pkg::IDX_W-1:0]    in_idx;
  logic [lbms_pkg::TIME_W-1:0]   in_now;
  lbms_pkg::mode_t               in_mode;
  logic [lbms_pkg::COUNT_W-1:0]  in_count;
  logic [lbms_pkg::PERIOD_W-1:0] in_period;

  // result register
  logic                          out_valid;
  logic [lbms_pkg::LEVEL_W-1:0]  out_levels;
  logic                          out_status;

  logic                          adv;
  logic                          idx_ok;
  logic                          bad;
  logic [lbms_pkg::LED_COUNT-1:0] lit;
  logic [lbms_pkg::LEVEL_W-1:0]  levels_next;

  assign adv           = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || adv;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slow_period <= lbms_pkg::SLOW_PERIOD_RESET;
      fast_period <= lbms_pkg::FAST_PERIOD_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == lbms_pkg::REG_SLOW_PERIOD) begin
        slow_period <= cfg_data;
      end
      if (cfg_index == lbms_pkg::REG_FAST_PERIOD) begin
        fast_period <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd    <= lbms_pkg::cmd_t'(s_axis_tdata[1:0]);
      in_idx    <= s_axis_tdata[4:2];
      in_now    <= s_axis_tdata[36:5];
      in_mode   <= lbms_pkg::mode_t'(s_axis_tdata[38:37]);
      in_count  <= s_axis_tdata[46:39];
      in_period <= s_axis_tdata[62:47];
    end
  end

  assign idx_ok = ({1'b0, in_idx} < (lbms_pkg::IDX_W + 1)'(lbms_pkg::LED_COUNT));
  assign bad    = ((in_cmd == lbms_pkg::CMD_SET_MODE) && !idx_ok) ||
                  ((in_cmd == lbms_pkg::CMD_START_SEQ) &&
                   (!idx_ok || in_count == '0 || in_period == '0));

  for (genvar i = 0; i < lbms_pkg::LED_COUNT; i++) begin : g_led
    lbms_pkg::led_ctl_t ctl;

    always_comb begin
      ctl.tick        = (in_cmd == lbms_pkg::CMD_TICK);
      ctl.set_mode    = (in_cmd == lbms_pkg::CMD_SET_MODE) &&
                        (in_idx == lbms_pkg::IDX_W'(i));
      ctl.start_seq   = (in_cmd == lbms_pkg::CMD_START_SEQ) &&
                        (in_idx == lbms_pkg::IDX_W'(i)) && !bad;
      ctl.clear_all   = (in_cmd == lbms_pkg::CMD_ALL_OFF);
      ctl.now         = in_now;
      ctl.mode        = in_mode;
      ctl.count       = in_count;
      ctl.period      = in_period;
      ctl.slow_period = slow_period;
      ctl.fast_period = fast_period;
    end

    lbms_led u_led (
      .clk (clk),
      .rst (rst),
      .en  (adv),
      .ctl (ctl),
      .lit (lit[i])
    );
  end

  // LEDs above the result width are not reported.
  // The LED registers load on the same edge as the result register, so they
  // already hold the levels after the request held in the result register.
  for (genvar j = 0; j < lbms_pkg::LEVEL_W; j++) begin : g_level
    if (j < lbms_pkg::LED_COUNT) begin : g_used
      assign levels_next[j] = lit[j];
    end else begin : g_unused
      assign levels_next[j] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_status <= bad;
    end
  end

  assign out_levels    = levels_next;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(lbms_pkg::OUT_DATA_W - lbms_pkg::LEVEL_W - 1)'(0),
                          out_status, out_levels};

  a_stall_holds_request: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !adv) |=> in_valid)
    else $error("pending request dropped");

  a_advance_gives_result: assert property (@(posedge clk) disable iff (rst)
    adv |=> m_axis_tvalid)
    else $error("request advanced without a result");

  a_bad_request_no_change: assert property (@(posedge clk) disable iff (rst)
    (adv && bad) |=> (lit == $past(lit)))
    else $error("invalid request changed LED state");

endmodule

### bench/testbench.sv
// Self-checking testbench for the LED blink mode sequencer.
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    lbms_pkg::cmd_t                cmd;
    logic [lbms_pkg::IDX_W-1:0]    idx;
    logic [lbms_pkg::TIME_W-1:0]   now;
    lbms_pkg::mode_t               mode;
    logic [lbms_pkg::COUNT_W-1:0]  count;
    logic [lbms_pkg::PERIOD_W-1:0] period;
  } led_req_t;

  typedef struct {
    logic [lbms_pkg::LEVEL_W-1:0] levels;
    logic                         status;
  } led_result_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic [lbms_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [lbms_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [lbms_pkg::REG_IDX_W-1:0]  cfg_index = '0;
  logic [lbms_pkg::PERIOD_W-1:0]   cfg_data = '0;

  led_blink_mode_sequencer uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // shadow LED state
  lbms_pkg::mode_t               sim_mode       [lbms_pkg::LED_COUNT];
  logic                          sim_lit        [lbms_pkg::LED_COUNT];
  logic [lbms_pkg::TIME_W-1:0]   sim_stamp      [lbms_pkg::LED_COUNT];
  logic                          sim_seq_on     [lbms_pkg::LED_COUNT];
  logic [lbms_pkg::TOGGLE_W-1:0] sim_toggles    [lbms_pkg::LED_COUNT];
  logic [lbms_pkg::PERIOD_W-1:0] sim_seq_period [lbms_pkg::LED_COUNT];
  lbms_pkg::mode_t               sim_final_mode [lbms_pkg::LED_COUNT];
  logic [lbms_pkg::PERIOD_W-1:0] sim_slow_ms = lbms_pkg::SLOW_PERIOD_RESET;
  logic [lbms_pkg::PERIOD_W-1:0] sim_fast_ms = lbms_pkg::FAST_PERIOD_RESET;

  led_req_t    cmd_backlog[$];
  led_result_t levels_due[$];
  led_req_t    cur_req;
  int          err_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_asked = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  logic [lbms_pkg::TIME_W-1:0] now_ms = '0;

  initial begin
    for (int i = 0; i < lbms_pkg::LED_COUNT; i++) begin
      sim_mode[i]       = lbms_pkg::MODE_OFF;
      sim_lit[i]        = 1'b0;
      sim_stamp[i]      = '0;
      sim_seq_on[i]     = 1'b0;
      sim_toggles[i]    = '0;
      sim_seq_period[i] = '0;
      sim_final_mode[i] = lbms_pkg::MODE_OFF;
    end
  end

  function automatic void clear_led(int i, logic [lbms_pkg::TIME_W-1:0] t);
    sim_mode[i]       = lbms_pkg::MODE_OFF;
    sim_lit[i]        = 1'b0;
    sim_stamp[i]      = t;
    sim_seq_on[i]     = 1'b0;
    sim_toggles[i]    = '0;
    sim_seq_period[i] = '0;
    sim_final_mode[i] = lbms_pkg::MODE_OFF;
  endfunction

  function automatic led_result_t led_step(led_req_t r);
    led_result_t                   res;
    logic [lbms_pkg::TIME_W-1:0]   elapsed;
    logic [lbms_pkg::PERIOD_W-1:0] period;
    int                            k;
    res.status = 1'b0;
    k          = int'(r.idx);
    case (r.cmd)
      lbms_pkg::CMD_TICK: begin
        for (int i = 0; i < lbms_pkg::LED_COUNT; i++) begin
          elapsed = r.now - sim_stamp[i];
          if (sim_seq_on[i]) begin
            if (elapsed >= lbms_pkg::TIME_W'(sim_seq_period[i])) begin
              sim_lit[i]   = ~sim_lit[i];
              sim_stamp[i] = r.now;
              if (sim_toggles[i] != 0)
                sim_toggles[i] = sim_toggles[i] - lbms_pkg::TOGGLE_W'(1);
              if (sim_toggles[i] == 0) begin
                sim_seq_on[i] = 1'b0;
                sim_mode[i]   = sim_final_mode[i];
                sim_lit[i]    = (sim_mode[i] != lbms_pkg::MODE_OFF);
              end
            end
          end else if (sim_mode[i] == lbms_pkg::MODE_OFF) begin
            sim_lit[i] = 1'b0;
          end else if (sim_mode[i] == lbms_pkg::MODE_ON) begin
            sim_lit[i] = 1'b1;
          end else begin
            period = (sim_mode[i] == lbms_pkg::MODE_SLOW) ? sim_slow_ms : sim_fast_ms;
            if (elapsed >= lbms_pkg::TIME_W'(period)) begin
              sim_lit[i]   = ~sim_lit[i];
              sim_stamp[i] = r.now;
            end
          end
        end
      end
      lbms_pkg::CMD_SET_MODE: begin
        if (k >= lbms_pkg::LED_COUNT) begin
          res.status = 1'b1;
        end else begin
          clear_led(k, r.now);
          sim_mode[k] = r.mode;
          sim_lit[k]  = (r.mode != lbms_pkg::MODE_OFF);
        end
      end
      lbms_pkg::CMD_START_SEQ: begin
        if (k >= lbms_pkg::LED_COUNT || r.count == 0 || r.period == 0) begin
          res.status = 1'b1;
        end else begin
          sim_seq_on[k]     = 1'b1;
          sim_toggles[k]    = {r.count, 1'b0} - lbms_pkg::TOGGLE_W'(1);
          sim_seq_period[k] = r.period;
          sim_final_mode[k] = r.mode;
          sim_stamp[k]      = r.now;
          sim_lit[k]        = 1'b1;
        end
      end
      default: begin
        for (int i = 0; i < lbms_pkg::LED_COUNT; i++) clear_led(i, r.now);
      end
    endcase
    res.levels = {sim_lit[1], sim_lit[0]};
    return res;
  endfunction

  task automatic flag_error(string what, logic [7:0] got, logic [7:0] want);
    $display("%0t ERROR %s: got %0h expected %0h", $time, what, got, want);
    err_count++;
  endtask

  // request driver
  always @(posedge clk) begin : drive_requests
    bit taken;
    taken = s_axis_tvalid && s_axis_tready;
    if (taken) levels_due.push_back(led_step(cur_req));
    @(negedge clk);
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || taken) begin
      if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cur_req = cmd_backlog.pop_front();
        s_axis_tdata <= {1'b0, cur_req.period, cur_req.count, cur_req.mode,
                         cur_req.now, cur_req.idx, cur_req.cmd};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result side backpressure
  always @(negedge clk) begin
    if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left   = 150;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin : check_results
    led_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (levels_due.size() == 0) begin
        flag_error("result with nothing pending", m_axis_tdata, 8'h00);
      end else begin
        want = levels_due.pop_front();
        if (m_axis_tdata[1:0] !== want.levels)
          flag_error("led_levels", 8'(m_axis_tdata[1:0]), 8'(want.levels));
        if (m_axis_tdata[2] !== want.status)
          flag_error("status", 8'(m_axis_tdata[2]), 8'(want.status));
      end
    end
  end

  task automatic add_req(lbms_pkg::cmd_t c, int idx, logic [lbms_pkg::TIME_W-1:0] t,
                         lbms_pkg::mode_t m, int cnt, int per);
    led_req_t r;
    r.cmd    = c;
    r.idx    = lbms_pkg::IDX_W'(idx);
    r.now    = t;
    r.mode   = m;
    r.count  = lbms_pkg::COUNT_W'(cnt);
    r.period = lbms_pkg::PERIOD_W'(per);
    cmd_backlog.push_back(r);
  endtask

  task automatic wait_idle();
    while (cmd_backlog.size() != 0 || s_axis_tvalid || levels_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_period(logic [lbms_pkg::REG_IDX_W-1:0] idx,
                              logic [lbms_pkg::PERIOD_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == lbms_pkg::REG_SLOW_PERIOD) sim_slow_ms = value;
    else sim_fast_ms = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_run(int n, int span);
    led_req_t r;
    int       pick;
    int       sub;
    repeat (n) begin
      pick     = $urandom_range(0, 99);
      r.idx    = lbms_pkg::IDX_W'($urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0) r.idx = lbms_pkg::IDX_W'($urandom_range(0, 7));
      r.mode   = lbms_pkg::mode_t'($urandom_range(0, 3));
      r.count  = lbms_pkg::COUNT_W'($urandom_range(0, 255));
      r.period = lbms_pkg::PERIOD_W'($urandom_range(0, 65535));
      if (pick < 3) now_ms = $urandom;
      else now_ms = now_ms + $urandom_range(0, span);
      r.now = now_ms;
      if (pick < 55) begin
        r.cmd = lbms_pkg::CMD_TICK;
      end else if (pick < 70) begin
        r.cmd = lbms_pkg::CMD_SET_MODE;
      end else if (pick < 90) begin
        r.cmd = lbms_pkg::CMD_START_SEQ;
        sub   = $urandom_range(0, 19);
        if (sub < 16) begin
          r.count  = lbms_pkg::COUNT_W'($urandom_range(1, 4));
          r.period = lbms_pkg::PERIOD_W'($urandom_range(1, span));
        end else if (sub == 16) begin
          r.count = '0;
        end else if (sub == 17) begin
          r.period = '0;
        end
      end else begin
        r.cmd = lbms_pkg::CMD_ALL_OFF;
      end
      cmd_backlog.push_back(r);
    end
  endtask

  initial begin
    #3_000_000;
    $display("led_blink_mode_sequencer verification failed");
    $finish;
  end

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // directed: reset periods, no idling
    add_req(lbms_pkg::CMD_TICK,      0, 32'd0,   lbms_pkg::MODE_OFF,  0,   0);
    add_req(lbms_pkg::CMD_SET_MODE,  0, 32'd10,  lbms_pkg::MODE_ON,   0,   0);
    add_req(lbms_pkg::CMD_SET_MODE,  1, 32'd20,  lbms_pkg::MODE_SLOW, 255, 65535);
    add_req(lbms_pkg::CMD_TICK,      7, 32'd519, lbms_pkg::MODE_FAST, 255, 65535);
    add_req(lbms_pkg::CMD_TICK,      0, 32'd520, lbms_pkg::MODE_OFF,  0,   0);
    add_req(lbms_pkg::CMD_SET_MODE,  7, 32'd530, lbms_pkg::MODE_ON,   1,   1);
    add_req(lbms_pkg::CMD_START_SEQ, 0, 32'd540, lbms_pkg::MODE_ON,   0,   100);
    add_req(lbms_pkg::CMD_START_SEQ, 0, 32'd550, lbms_pkg::MODE_ON,   3,   0);
    add_req(lbms_pkg::CMD_START_SEQ, 2, 32'd560, lbms_pkg::MODE_ON,   3,   100);
    add_req(lbms_pkg::CMD_START_SEQ, 0, 32'd600, lbms_pkg::MODE_FAST, 1,   100);
    add_req(lbms_pkg::CMD_TICK,      0, 32'd699, lbms_pkg::MODE_OFF,  0,   0);
    add_req(lbms_pkg::CMD_TICK,      0, 32'd700, lbms_pkg::MODE_OFF,  0,   0);
    add_req(lbms_pkg::CMD_TICK,      0, 32'd850, lbms_pkg::MODE_OFF,  0,   0);
    add_req(lbms_pkg::CMD_START_SEQ, 1, 32'd900, lbms_pkg::MODE_OFF,  255, 65535);
    add_req(lbms_pkg::CMD_TICK, 0, 32'd900 + 32'd65534, lbms_pkg::MODE_OFF, 0, 0);
    add_req(lbms_pkg::CMD_TICK, 0, 32'd900 + 32'd65535, lbms_pkg::MODE_OFF, 0, 0);
    add_req(lbms_pkg::CMD_SET_MODE, 1, 32'd70000, lbms_pkg::MODE_FAST, 0, 0);
    add_req(lbms_pkg::CMD_ALL_OFF,  7, 32'hFFFF_FFF0, lbms_pkg::MODE_FAST, 255, 65535);
    add_req(lbms_pkg::CMD_SET_MODE, 0, 32'hFFFF_FFF0, lbms_pkg::MODE_SLOW, 0, 0);
    add_req(lbms_pkg::CMD_SET_MODE, 1, 32'hFFFF_FFF0, lbms_pkg::MODE_FAST, 0, 0);
    add_req(lbms_pkg::CMD_TICK,     0, 32'h0000_01E3, lbms_pkg::MODE_OFF, 0, 0);
    add_req(lbms_pkg::CMD_TICK,     0, 32'h0000_01E4, lbms_pkg::MODE_OFF, 0, 0);
    add_req(lbms_pkg::CMD_SET_MODE, 1, 32'h0000_0200, lbms_pkg::MODE_OFF, 0, 0);
    add_req(lbms_pkg::CMD_TICK,     7, 32'hFFFF_FFFF, lbms_pkg::MODE_FAST, 255, 65535);
    wait_idle();

    write_period(lbms_pkg::REG_SLOW_PERIOD, 16'd40);
    write_period(lbms_pkg::REG_FAST_PERIOD, 16'd13);
    now_ms = 32'd1000;
    random_run(100, 60);
    wait_idle();
    random_run(100, 60);
    wait_idle();

    write_period(lbms_pkg::REG_SLOW_PERIOD, 16'd1);
    write_period(lbms_pkg::REG_FAST_PERIOD, 16'hFFFF);
    send_idle_pct = 74;
    random_run(200, 40);
    wait_idle();

    write_period(lbms_pkg::REG_SLOW_PERIOD, 16'hFFFF);
    write_period(lbms_pkg::REG_FAST_PERIOD, 16'd1);
    send_idle_pct  = 0;
    recv_stall_pct = 74;
    random_run(200, 100);
    wait_idle();

    // zero periods: blinking LEDs toggle on every tick
    write_period(lbms_pkg::REG_SLOW_PERIOD, 16'd0);
    write_period(lbms_pkg::REG_FAST_PERIOD, 16'd0);
    send_idle_pct  = 21;
    recv_stall_pct = 21;
    random_run(200, 20);
    wait_idle();

    write_period(lbms_pkg::REG_SLOW_PERIOD, 16'($urandom_range(1, 300)));
    write_period(lbms_pkg::REG_FAST_PERIOD, 16'($urandom_range(1, 300)));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    now_ms         = 32'hFFFF_FF00;
    hold_asked++;
    random_run(200, 150);
    wait_idle();

    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("led_blink_mode_sequencer verification clean");
    end else begin
      $display("led_blink_mode_sequencer verification failed");
    end
    $finish;
  end

endmodule
